[hdl/rptw_pkg.sv]
// ----------------------------------------------------------------------------
// rptw_pkg
// Types, codes and address helpers shared by the page table walker modules.
// ----------------------------------------------------------------------------
package rptw_pkg;

    // Base page offset width
    localparam int unsigned PAGE_SHIFT = 12;

    // Width of the configuration data bus and address
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 5;

    // Configuration register indexes (byte address is 8 * index)
    localparam logic [1:0] REG_XLEN_IS_64       = 2'd0;
    localparam logic [1:0] REG_TRANSLATION_MODE = 2'd1;
    localparam logic [1:0] REG_ROOT_PAGE_NUMBER = 2'd2;

    // Input operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_PTE     = 1'b1;

    // Access kinds
    localparam logic [1:0] ACC_FETCH = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;

    // Translation modes
    localparam logic [2:0] MODE_BARE = 3'd0;
    localparam logic [2:0] MODE_SV32 = 3'd1;
    localparam logic [2:0] MODE_SV39 = 3'd2;
    localparam logic [2:0] MODE_SV48 = 3'd3;
    localparam logic [2:0] MODE_SV57 = 3'd4;

    // Fault causes
    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_FETCH = 2'd1;
    localparam logic [1:0] CAUSE_LOAD  = 2'd2;
    localparam logic [1:0] CAUSE_STORE = 2'd3;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PTE_READ = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_FAULT    = 2'd2
    } t_kind;

    // Configuration register contents
    typedef struct packed {
        logic        xlen_is_64;
        logic [2:0]  translation_mode;
        logic [43:0] root_page_number;
    } t_cfg;

    // Walk state carried between transactions
    typedef struct packed {
        logic        busy;
        logic [2:0]  level;
        logic [63:0] saved_vaddr;
        logic [1:0]  saved_access;
        logic [6:0]  saved_size;
    } t_walk;

    // One result transaction
    typedef struct packed {
        t_kind       kind;
        logic [63:0] address;
        logic [6:0]  size;
        logic [1:0]  cause;
    } t_result;

    // Bit position of the VPN field at a given level, above the page offset
    function automatic logic [5:0] vpn_shift(input logic sv32, input logic [2:0] idx);
        logic [5:0] sh;
        case (idx)
            3'd0:    sh = 6'd0;
            3'd1:    sh = sv32 ? 6'd10 : 6'd9;
            3'd2:    sh = sv32 ? 6'd20 : 6'd18;
            3'd3:    sh = sv32 ? 6'd30 : 6'd27;
            3'd4:    sh = sv32 ? 6'd40 : 6'd36;
            default: sh = 6'd0;
        endcase
        return sh;
    endfunction

    // Address of the PTE for one level: table base plus scaled VPN field
    function automatic logic [63:0] pte_addr(input logic [63:0] base,
                                             input logic [63:0] va,
                                             input logic        sv32,
                                             input logic        xlen64,
                                             input logic [2:0]  idx);
        logic [6:0]  sh;
        logic [63:0] shifted;
        logic [9:0]  vpn;
        logic [12:0] offs;
        sh      = 7'(PAGE_SHIFT) + {1'b0, vpn_shift(sv32, idx)};
        shifted = va >> sh;
        vpn     = shifted[9:0];
        if (!sv32) begin
            vpn[9] = 1'b0;
        end
        offs = xlen64 ? {vpn, 3'b000} : {1'b0, vpn, 2'b00};
        return base + {51'd0, offs};
    endfunction

    // Fault cause for an access kind
    function automatic logic [1:0] cause_of(input logic [1:0] acc);
        logic [1:0] c;
        case (acc)
            ACC_FETCH: c = CAUSE_FETCH;
            ACC_STORE: c = CAUSE_STORE;
            default:   c = CAUSE_LOAD;
        endcase
        return c;
    endfunction

endpackage

[hdl/riscv_page_table_walker.sv]
// ----------------------------------------------------------------------------
// riscv_page_table_walker
// RISC-V page table walker for bare, Sv32, Sv39, Sv48 and Sv57 translation.
// ----------------------------------------------------------------------------
// Each transaction (a translation request or a PTE returned from memory) is
// decoded combinationally and its result, if any, appears in the output register
// on the next cycle. A new transaction is taken every cycle; the input stalls
// only while the output register holds a result that the consumer stalls.
// The walk itself spans one PTE read per level, driven by the caller, who
// feeds each returned PTE back as a new transaction. Configuration is read and
// written over the register port; registers lie at byte addresses 0, 8, 16.
module riscv_page_table_walker
    import rptw_pkg::*;
#(
    parameter int unsigned MAX_LEVELS = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request / PTE channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [63:0]           i_virt_addr,
    input  logic [1:0]            i_access_kind,
    input  logic                  i_in_machine_mode,
    input  logic [6:0]            i_access_size,
    input  logic [63:0]           i_pte_word,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_kind,
    output logic [63:0]           o_address,
    output logic [6:0]            o_size_out,
    output logic [1:0]            o_fault_cause,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    r_cfg;
    t_walk   r_walk;
    t_walk   n_walk;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    n_res_valid;
    logic    in_acc;
    logic    cfg_wr;
    logic [1:0] cfg_idx;

    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xlen_is_64       <= 1'b1;
            r_cfg.translation_mode <= MODE_BARE;
            r_cfg.root_page_number <= 44'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_XLEN_IS_64:       r_cfg.xlen_is_64       <= pwdata[0];
                REG_TRANSLATION_MODE: r_cfg.translation_mode <= pwdata[2:0];
                REG_ROOT_PAGE_NUMBER: r_cfg.root_page_number <= pwdata[43:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            REG_XLEN_IS_64:       prdata = {63'd0, r_cfg.xlen_is_64};
            REG_TRANSLATION_MODE: prdata = {61'd0, r_cfg.translation_mode};
            REG_ROOT_PAGE_NUMBER: prdata = {20'd0, r_cfg.root_page_number};
            default:              prdata = '0;
        endcase
    end

    // Decode one transaction
    rptw_step #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_step (
        .i_cfg             (r_cfg),
        .i_walk            (r_walk),
        .i_op              (i_op),
        .i_virt_addr       (i_virt_addr),
        .i_access_kind     (i_access_kind),
        .i_in_machine_mode (i_in_machine_mode),
        .i_access_size     (i_access_size),
        .i_pte_word        (i_pte_word),
        .o_walk            (n_walk),
        .o_res_valid       (n_res_valid),
        .o_res             (n_out)
    );

    // Hold input while a stalled result occupies the output register
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Walk state: advance on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk.busy  <= 1'b0;
            r_walk.level <= 3'd0;
        end else if (in_acc) begin
            r_walk <= n_walk;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && n_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_res_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_address     = r_out.address;
    assign o_size_out    = r_out.size;
    assign o_fault_cause = r_out.cause;

    // Machine-mode request completes with a finished translation
    a_mmode_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_op == OP_REQUEST && i_in_machine_mode
        |=> o_out_valid && o_kind == KIND_DONE)
        else $error("machine-mode request did not pass through");

    // A PTE with no walk in progress gives no result
    a_stray_pte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_op == OP_PTE && !r_walk.busy |=> !o_out_valid)
        else $error("stray PTE produced a result");

    // A busy walk always has a level in range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk.busy |-> r_walk.level != 3'd0 && 32'(r_walk.level) <= MAX_LEVELS)
        else $error("walk busy with bad level");

    // A fault carries a cause and no address
    a_fault_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_FAULT
        |-> o_fault_cause != CAUSE_NONE && o_address == 64'd0)
        else $error("fault result fields inconsistent");

endmodule

[hdl/rptw_step.sv]
// ----------------------------------------------------------------------------
// rptw_step
// Single-pass decode of one transaction: next walk state and the result.
// ----------------------------------------------------------------------------
module rptw_step
    import rptw_pkg::*;
#(
    parameter int unsigned MAX_LEVELS = 5
) (
    input  t_cfg        i_cfg,
    input  t_walk       i_walk,
    input  logic        i_op,
    input  logic [63:0] i_virt_addr,
    input  logic [1:0]  i_access_kind,
    input  logic        i_in_machine_mode,
    input  logic [6:0]  i_access_size,
    input  logic [63:0] i_pte_word,
    output t_walk       o_walk,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic        sv32;
    logic [2:0]  levels;
    logic [63:0] va_req;
    logic [43:0] root;
    logic [63:0] base_req;
    logic [63:0] pte;
    logic [43:0] ppn;
    logic [2:0]  idx;
    logic        pv, pr, pw, px;
    logic [51:0] vbase;
    logic [51:0] low_mask;
    logic [43:0] merged;
    logic [63:0] pa;
    logic [63:0] base_next;
    logic        walk_ok;

    // Decode configuration
    always_comb begin
        sv32 = (i_cfg.translation_mode == MODE_SV32);
        unique case (i_cfg.translation_mode)
            MODE_SV32: levels = 3'd2;
            MODE_SV39: levels = 3'd3;
            MODE_SV48: levels = 3'd4;
            MODE_SV57: levels = 3'd5;
            default:   levels = 3'd0;
        endcase
        if (32'(levels) > MAX_LEVELS) begin
            levels = 3'd0;
        end
    end

    // Request side operands
    assign va_req   = i_cfg.xlen_is_64 ? i_virt_addr : {32'd0, i_virt_addr[31:0]};
    assign root     = i_cfg.xlen_is_64 ? i_cfg.root_page_number
                                       : {22'd0, i_cfg.root_page_number[21:0]};
    assign base_req = {8'd0, root, 12'd0};

    // PTE side operands
    assign pte       = i_cfg.xlen_is_64 ? i_pte_word : {32'd0, i_pte_word[31:0]};
    assign ppn       = sv32 ? {22'd0, pte[31:10]} : pte[53:10];
    assign idx       = i_walk.level - 3'd1;
    assign pv        = pte[0];
    assign pr        = pte[1];
    assign pw        = pte[2];
    assign px        = pte[3];
    assign vbase     = i_walk.saved_vaddr[63:12];
    assign low_mask  = ~({52{1'b1}} << vpn_shift(sv32, idx));
    assign merged    = ppn | 44'(vbase & low_mask);
    assign pa        = {8'd0, merged, i_walk.saved_vaddr[11:0]};
    assign base_next = {8'd0, ppn, 12'd0};
    assign walk_ok   = i_walk.busy && (i_walk.level != 3'd0)
                       && (32'(i_walk.level) <= MAX_LEVELS);

    // Next state and result
    always_comb begin
        o_walk      = i_walk;
        o_res_valid = 1'b0;
        o_res.kind    = KIND_FAULT;
        o_res.address = 64'd0;
        o_res.size    = 7'd0;
        o_res.cause   = CAUSE_NONE;
        if (i_op == OP_REQUEST) begin
            // Start a walk, or pass the address straight through
            o_walk.saved_vaddr  = va_req;
            o_walk.saved_access = i_access_kind;
            o_walk.saved_size   = i_access_size;
            o_res_valid         = 1'b1;
            if (levels == 3'd0 || i_in_machine_mode) begin
                o_walk.busy   = 1'b0;
                o_walk.level  = 3'd0;
                o_res.kind    = KIND_DONE;
                o_res.address = va_req;
                o_res.size    = i_access_size;
            end else begin
                o_walk.busy       = 1'b1;
                o_walk.level      = levels;
                o_res.kind        = KIND_PTE_READ;
                o_res.address     = pte_addr(base_req, va_req, sv32, i_cfg.xlen_is_64,
                                             levels - 3'd1);
            end
        end else if (!walk_ok) begin
            // Stray PTE: drop it
            o_walk.busy = 1'b0;
        end else begin
            o_res_valid = 1'b1;
            if (!pv || (!pr && pw)) begin
                // Invalid entry
                o_walk.busy  = 1'b0;
                o_walk.level = 3'd0;
                o_res.cause  = cause_of(i_walk.saved_access);
            end else if (pr || px) begin
                // Leaf: check permission, then merge superpage bits
                o_walk.busy  = 1'b0;
                o_walk.level = 3'd0;
                if (i_walk.saved_access != ACC_FETCH
                    && i_walk.saved_access == ACC_STORE && !pw) begin
                    o_res.cause = CAUSE_STORE;
                end else if (i_walk.saved_access != ACC_FETCH && !pr) begin
                    o_res.cause = CAUSE_LOAD;
                end else begin
                    o_res.kind    = KIND_DONE;
                    o_res.address = pa;
                    o_res.size    = i_walk.saved_size;
                end
            end else if (idx == 3'd0) begin
                // Pointer at the last level
                o_walk.busy  = 1'b0;
                o_walk.level = 3'd0;
                o_res.cause  = cause_of(i_walk.saved_access);
            end else begin
                // Descend one level
                o_walk.level      = idx;
                o_res.kind        = KIND_PTE_READ;
                o_res.address     = pte_addr(base_next, i_walk.saved_vaddr, sv32,
                                             i_cfg.xlen_is_64, idx - 3'd1);
            end
        end
    end

endmodule

[sim/riscv_page_table_walker_test.sv]
// ----------------------------------------------------------------------------
// riscv_page_table_walker_test
// Self-checking testbench for the RISC-V page table walker.
// ----------------------------------------------------------------------------
// A short directed table covers pass-through, every fault cause, walks to the
// last level, superpage leaves, abandoned walks and 32-bit addressing. Random
// phases follow, each with its own register setting and idle pattern. Most
// random traffic is well-formed walks: a request followed by pointer and leaf
// PTEs with random content, mixed with stray PTEs and abandoned walks. Every
// accepted transaction runs through a local model of the walker, and each
// result transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module riscv_page_table_walker_test
    import rptw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF       = 4;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned WALK_DEPTH_MAX = 5;
    localparam int unsigned PHASES         = 8;
    localparam int unsigned PHASE_ITEMS    = 160;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned QUIET_LIMIT    = 2000;
    localparam int unsigned MAX_PRINTED    = 40;

    // Codes outside the package lists
    localparam logic [1:0] ACC_RESERVED    = 2'd3;
    localparam logic [2:0] MODE_BARE_ALIAS = 3'd7;

    // PTE flag bit positions and flag bytes
    localparam int unsigned PTE_V = 0;
    localparam int unsigned PTE_R = 1;
    localparam int unsigned PTE_W = 2;
    localparam int unsigned PTE_X = 3;
    localparam logic [7:0] FLAGS_PTR   = 8'h01;
    localparam logic [7:0] FLAGS_RO    = 8'h03;
    localparam logic [7:0] FLAGS_WNOR  = 8'h05;
    localparam logic [7:0] FLAGS_XO    = 8'h09;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [43:0] ROOT_MAX = 44'hFFF_FFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [63:0] va;
        logic [1:0]  acc;
        logic        mm;
        logic [6:0]  size;
        logic [63:0] pte;
    } t_walk_item;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   rk;
        t_walk_item  it;
        bit          typed;
        t_result     want;
        logic [1:0]  reg_idx;
        logic [63:0] reg_val;
    } t_dir_row;

    // DUT signals
    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_stall;
    logic                  i_op              = OP_REQUEST;
    logic [63:0]           i_virt_addr       = '0;
    logic [1:0]            i_access_kind     = ACC_FETCH;
    logic                  i_in_machine_mode = 1'b0;
    logic [6:0]            i_access_size     = '0;
    logic [63:0]           i_pte_word        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall       = 1'b0;
    logic [1:0]            o_kind;
    logic [63:0]           o_address;
    logic [6:0]            o_size_out;
    logic [1:0]            o_fault_cause;
    logic                  psel              = 1'b0;
    logic                  penable           = 1'b0;
    logic                  pwrite            = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr             = '0;
    logic [CFG_DATA_W-1:0] pwdata            = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Model copy of the registers and walk state
    logic        cfg_xlen64 = 1'b1;
    logic [2:0]  cfg_mode   = MODE_BARE;
    logic [43:0] cfg_root   = '0;
    logic        wk_busy    = 1'b0;
    logic [63:0] wk_vaddr   = '0;
    logic [1:0]  wk_access  = ACC_FETCH;
    logic [6:0]  wk_size    = '0;
    logic [2:0]  wk_level   = '0;
    logic [63:0] wk_base    = '0;

    t_result     pending_results[$];
    t_dir_row    directed_rows[$];
    bit          typed_active = 1'b0;
    t_result     typed_want;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;

    riscv_page_table_walker #(
        .MAX_LEVELS(WALK_DEPTH_MAX)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_virt_addr       (i_virt_addr),
        .i_access_kind     (i_access_kind),
        .i_in_machine_mode (i_in_machine_mode),
        .i_access_size     (i_access_size),
        .i_pte_word        (i_pte_word),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_address         (o_address),
        .o_size_out        (o_size_out),
        .o_fault_cause     (o_fault_cause),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Generate the clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Walker model
    // ------------------------------------------------------------------
    function automatic t_result mk_result(t_kind k, logic [63:0] a, logic [6:0] s,
                                          logic [1:0] c);
        t_result res;
        res.kind    = k;
        res.address = a;
        res.size    = s;
        res.cause   = c;
        return res;
    endfunction

    function automatic int unsigned mode_depth(logic [2:0] mode);
        int unsigned n;
        case (mode)
            MODE_SV32: n = 2;
            MODE_SV39: n = 3;
            MODE_SV48: n = 4;
            MODE_SV57: n = 5;
            default:   n = 0;
        endcase
        if (n > WALK_DEPTH_MAX) n = 0;
        return n;
    endfunction

    function automatic int unsigned vpn_width();
        return (cfg_mode == MODE_SV32) ? 10 : 9;
    endfunction

    // Table base plus the scaled VPN field of one level
    function automatic logic [63:0] entry_addr(logic [63:0] base, logic [63:0] va,
                                               int unsigned idx);
        int unsigned w;
        logic [63:0] vpn;
        w   = vpn_width();
        vpn = (va >> (PAGE_SHIFT + w * idx)) & ((64'd1 << w) - 64'd1);
        return base + vpn * (cfg_xlen64 ? 64'd8 : 64'd4);
    endfunction

    function automatic logic [63:0] entry_ppn(logic [63:0] pte);
        if (cfg_mode == MODE_SV32) return {42'd0, pte[31:10]};
        return {20'd0, pte[53:10]};
    endfunction

    function automatic logic [1:0] fault_for(logic [1:0] acc);
        if (acc == ACC_FETCH) return CAUSE_FETCH;
        if (acc == ACC_STORE) return CAUSE_STORE;
        return CAUSE_LOAD;
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [63:0] val);
        case (idx)
            REG_XLEN_IS_64:       cfg_xlen64 = val[0];
            REG_TRANSLATION_MODE: cfg_mode   = val[2:0];
            REG_ROOT_PAGE_NUMBER: cfg_root   = val[43:0];
            default: ;
        endcase
    endfunction

    // Advance the walk by one transaction; return 1 when it yields a result
    function automatic bit predict_walk(input t_walk_item it, output t_result res);
        logic [63:0] va;
        logic [63:0] pte;
        logic [63:0] low;
        logic [63:0] pa;
        int unsigned n;
        int unsigned idx;
        int unsigned ib;
        logic v, r, w, x;
        logic [1:0] fault;
        res = mk_result(KIND_PTE_READ, '0, '0, CAUSE_NONE);
        if (it.op == OP_REQUEST) begin
            va = cfg_xlen64 ? it.va : {32'd0, it.va[31:0]};
            n  = mode_depth(cfg_mode);
            wk_vaddr  = va;
            wk_access = it.acc;
            wk_size   = it.size;
            // Bare, reserved mode or machine mode: pass straight through
            if (n == 0 || it.mm) begin
                wk_busy  = 1'b0;
                wk_level = '0;
                res = mk_result(KIND_DONE, va, it.size, CAUSE_NONE);
                return 1'b1;
            end
            wk_base  = cfg_xlen64 ? (64'(cfg_root) << PAGE_SHIFT)
                                  : (64'(cfg_root[21:0]) << PAGE_SHIFT);
            wk_level = 3'(n);
            wk_busy  = 1'b1;
            res = mk_result(KIND_PTE_READ, entry_addr(wk_base, va, n - 1), '0, CAUSE_NONE);
            return 1'b1;
        end

        // Drop a PTE that arrives with no walk in progress
        if (!wk_busy || wk_level == 0 || wk_level > WALK_DEPTH_MAX) begin
            wk_busy = 1'b0;
            return 1'b0;
        end

        pte   = cfg_xlen64 ? it.pte : {32'd0, it.pte[31:0]};
        idx   = wk_level - 1;
        v     = pte[PTE_V];
        r     = pte[PTE_R];
        w     = pte[PTE_W];
        x     = pte[PTE_X];
        fault = fault_for(wk_access);

        if (!v || (!r && w)) begin
            wk_busy  = 1'b0;
            wk_level = '0;
            res = mk_result(KIND_FAULT, '0, '0, fault);
            return 1'b1;
        end

        // Leaf: check permissions, merge superpage bits
        if (r || x) begin
            ib  = vpn_width() * idx;
            low = (wk_vaddr >> PAGE_SHIFT) & ((64'd1 << ib) - 64'd1);
            wk_busy  = 1'b0;
            wk_level = '0;
            if (wk_access != ACC_FETCH) begin
                if (wk_access == ACC_STORE && !w) begin
                    res = mk_result(KIND_FAULT, '0, '0, CAUSE_STORE);
                    return 1'b1;
                end
                if (!r) begin
                    res = mk_result(KIND_FAULT, '0, '0, CAUSE_LOAD);
                    return 1'b1;
                end
            end
            pa  = ((entry_ppn(pte) | low) << PAGE_SHIFT) | {52'd0, wk_vaddr[11:0]};
            res = mk_result(KIND_DONE, pa, wk_size, CAUSE_NONE);
            return 1'b1;
        end

        // Pointer at the last level
        if (idx == 0) begin
            wk_busy  = 1'b0;
            wk_level = '0;
            res = mk_result(KIND_FAULT, '0, '0, fault);
            return 1'b1;
        end

        wk_base  = entry_ppn(pte) << PAGE_SHIFT;
        wk_level = 3'(idx);
        res = mk_result(KIND_PTE_READ, entry_addr(wk_base, wk_vaddr, idx - 1), '0, CAUSE_NONE);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] make_entry(logic [43:0] ppn, logic [7:0] flags);
        return {10'd0, ppn, 2'b00, flags};
    endfunction

    function automatic t_dir_row blank_row();
        t_dir_row d;
        d.rk      = ROW_ITEM;
        d.it      = '0;
        d.typed   = 1'b0;
        d.want    = mk_result(KIND_PTE_READ, '0, '0, CAUSE_NONE);
        d.reg_idx = '0;
        d.reg_val = '0;
        return d;
    endfunction

    function automatic t_dir_row req_row(logic [63:0] va, logic [1:0] acc, logic mm,
                                         logic [6:0] size);
        t_dir_row d;
        d         = blank_row();
        d.it.op   = OP_REQUEST;
        d.it.va   = va;
        d.it.acc  = acc;
        d.it.mm   = mm;
        d.it.size = size;
        return d;
    endfunction

    function automatic t_dir_row pte_row(logic [63:0] pte);
        t_dir_row d;
        d        = blank_row();
        d.it.op  = OP_PTE;
        d.it.pte = pte;
        return d;
    endfunction

    function automatic t_dir_row reg_row(logic [1:0] idx, logic [63:0] val);
        t_dir_row d;
        d         = blank_row();
        d.rk      = ROW_REG;
        d.reg_idx = idx;
        d.reg_val = val;
        return d;
    endfunction

    function automatic t_dir_row with_result(t_dir_row d, t_kind k, logic [63:0] a,
                                             logic [6:0] s, logic [1:0] c);
        d.typed = 1'b1;
        d.want  = mk_result(k, a, s, c);
        return d;
    endfunction

    function automatic logic [1:0] pick_access();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) return ACC_FETCH;
        if (roll < 6) return ACC_LOAD;
        if (roll < 9) return ACC_STORE;
        return ACC_RESERVED;
    endfunction

    // Random PTE: mostly pointer or leaf as asked, sometimes pure noise
    function automatic logic [63:0] random_entry(bit leaf);
        logic [63:0] e;
        logic r, w, x;
        int unsigned roll;
        e    = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 8) return e;
        r = 1'b0;
        w = 1'b0;
        x = 1'b0;
        if (leaf) begin
            r = 1'($urandom_range(0, 1));
            w = 1'($urandom_range(0, 1));
            x = 1'($urandom_range(0, 1));
            if (!r && !x) r = 1'b1;
            if (w && !r && roll < 80) r = 1'b1;
        end
        e[PTE_V] = 1'b1;
        e[PTE_R] = r;
        e[PTE_W] = w;
        e[PTE_X] = x;
        return e;
    endfunction

    // Follow the walk in progress; otherwise start a new one
    function automatic t_walk_item next_walk_item();
        t_walk_item it;
        int unsigned roll;
        it.op   = OP_REQUEST;
        it.va   = {$urandom, $urandom};
        it.acc  = pick_access();
        it.mm   = ($urandom_range(0, 9) == 0);
        it.size = 7'($urandom_range(0, 64));
        it.pte  = {$urandom, $urandom};
        roll    = $urandom_range(0, 99);
        if (wk_busy) begin
            if (roll >= 6) begin
                it.op  = OP_PTE;
                it.pte = random_entry((wk_level == 1) ? (roll < 90) : (roll < 40));
            end
        end else if (roll < 8) begin
            it.op = OP_PTE;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("%0t ns: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Drivers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------
    task automatic drive_item(input t_walk_item it, input bit is_typed, input t_result want);
        typed_active = is_typed;
        typed_want   = want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_op              <= it.op;
        i_virt_addr       <= it.va;
        i_access_kind     <= it.acc;
        i_in_machine_mode <= it.mm;
        i_access_size     <= it.size;
        i_pte_word        <= it.pte;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted result is out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random stall on the result side
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check results, track registers, predict accepted transactions
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_walk_item seen;
        t_result    pred;
        t_result    want;
        bit         has;
        bit         busy_edge;
        if (i_rst_n) begin
            busy_edge = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                busy_edge = 1'b1;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result address", o_address, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch("kind", 64'(o_kind), 64'(want.kind));
                    if (o_address !== want.address)
                        report_mismatch("address", o_address, want.address);
                    if (o_size_out !== want.size)
                        report_mismatch("size_out", 64'(o_size_out), 64'(want.size));
                    if (o_fault_cause !== want.cause)
                        report_mismatch("fault_cause", 64'(o_fault_cause), 64'(want.cause));
                end
            end
            if (psel && penable && pwrite && pready) begin
                busy_edge = 1'b1;
                apply_reg(paddr[CFG_ADDR_W-1:3], pwdata);
            end
            if (i_in_valid && !o_in_stall) begin
                busy_edge = 1'b1;
                seen = {i_op, i_virt_addr, i_access_kind, i_in_machine_mode,
                        i_access_size, i_pte_word};
                has  = predict_walk(seen, pred);
                if (has) pending_results.push_back(typed_active ? typed_want : pred);
            end
            quiet_cycles <= busy_edge ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_result     no_result;
        int unsigned ph;
        int unsigned k;
        logic [63:0] root_val;
        logic [2:0]  mode_val;
        logic        xlen_val;

        no_result = mk_result(KIND_PTE_READ, '0, '0, CAUSE_NONE);

        // Reset values: 64-bit, bare, root zero
        directed_rows.push_back(pte_row(ALL_ONES));
        directed_rows.push_back(with_result(req_row(ALL_ONES, ACC_STORE, 1'b0, 7'd64),
                                            KIND_DONE, ALL_ONES, 7'd64, CAUSE_NONE));
        directed_rows.push_back(with_result(req_row('0, ACC_FETCH, 1'b0, 7'd0),
                                            KIND_DONE, '0, 7'd0, CAUSE_NONE));
        // Sv39 with the highest root page
        directed_rows.push_back(reg_row(REG_TRANSLATION_MODE, 64'(MODE_SV39)));
        directed_rows.push_back(reg_row(REG_ROOT_PAGE_NUMBER, 64'(ROOT_MAX)));
        directed_rows.push_back(with_result(req_row(64'h1234_5678_9ABC_DEF0, ACC_LOAD,
                                                    1'b1, 7'd8),
                                            KIND_DONE, 64'h1234_5678_9ABC_DEF0, 7'd8,
                                            CAUSE_NONE));
        // Invalid PTE, then reserved W-without-R encoding
        directed_rows.push_back(req_row(64'h0000_007F_C030_1ABC, ACC_STORE, 1'b0, 7'd4));
        directed_rows.push_back(with_result(pte_row('0), KIND_FAULT, '0, '0, CAUSE_STORE));
        directed_rows.push_back(req_row(64'h0000_0040_2010_0FFF, ACC_LOAD, 1'b0, 7'd2));
        directed_rows.push_back(with_result(pte_row(make_entry(44'h1, FLAGS_WNOR)),
                                            KIND_FAULT, '0, '0, CAUSE_LOAD));
        // Pointer at the last level
        directed_rows.push_back(req_row(ALL_ONES, ACC_FETCH, 1'b0, 7'd1));
        directed_rows.push_back(pte_row(make_entry(44'hABC_DEF0_1234, FLAGS_PTR)));
        directed_rows.push_back(pte_row(make_entry(ROOT_MAX, FLAGS_PTR)));
        directed_rows.push_back(with_result(pte_row(make_entry('0, FLAGS_PTR)),
                                            KIND_FAULT, '0, '0, CAUSE_FETCH));
        // Store to a read-only leaf, load and reserved kind from execute-only
        directed_rows.push_back(req_row(64'h0000_0012_3456_7890, ACC_STORE, 1'b0, 7'd16));
        directed_rows.push_back(with_result(pte_row(make_entry(44'h1, FLAGS_RO)),
                                            KIND_FAULT, '0, '0, CAUSE_STORE));
        directed_rows.push_back(req_row(64'h0000_0012_3456_7890, ACC_LOAD, 1'b0, 7'd32));
        directed_rows.push_back(with_result(pte_row(make_entry(44'h2, FLAGS_XO)),
                                            KIND_FAULT, '0, '0, CAUSE_LOAD));
        directed_rows.push_back(req_row(64'h0000_0012_3456_7890, ACC_RESERVED, 1'b0, 7'd32));
        directed_rows.push_back(with_result(pte_row(make_entry(44'h3, FLAGS_XO)),
                                            KIND_FAULT, '0, '0, CAUSE_LOAD));
        // Misaligned superpage at the root, then an abandoned walk
        directed_rows.push_back(req_row(ALL_ONES, ACC_FETCH, 1'b0, 7'd64));
        directed_rows.push_back(pte_row(make_entry(44'h5_5555_5555, FLAGS_XO)));
        directed_rows.push_back(req_row(64'h0000_0001_8000_0000, ACC_LOAD, 1'b0, 7'd1));
        directed_rows.push_back(pte_row(make_entry(44'h7_0000, FLAGS_PTR)));
        directed_rows.push_back(req_row(64'h0000_003F_FFFF_F000, ACC_STORE, 1'b0, 7'd64));
        directed_rows.push_back(pte_row(ALL_ONES));
        // Reserved mode acts as bare
        directed_rows.push_back(reg_row(REG_TRANSLATION_MODE, 64'(MODE_BARE_ALIAS)));
        directed_rows.push_back(with_result(req_row(ALL_ONES, ACC_LOAD, 1'b0, 7'd64),
                                            KIND_DONE, ALL_ONES, 7'd64, CAUSE_NONE));
        // 32-bit entries with Sv32
        directed_rows.push_back(reg_row(REG_XLEN_IS_64, 64'd0));
        directed_rows.push_back(reg_row(REG_TRANSLATION_MODE, 64'(MODE_SV32)));
        directed_rows.push_back(req_row(ALL_ONES, ACC_LOAD, 1'b0, 7'd64));
        directed_rows.push_back(pte_row(64'hA5A5_A5A5_FFFF_FC01));
        directed_rows.push_back(pte_row(ALL_ONES));

        // Hold reset, then release at a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].rk == ROW_REG) begin
                drain_results();
                apb_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
                psel    <= 1'b0;
                penable <= 1'b0;
            end else begin
                drive_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, each with its own setting and idle pattern
        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (ph)
                0: mode_val = MODE_SV57;
                1: mode_val = MODE_SV32;
                2: mode_val = MODE_SV39;
                3: mode_val = MODE_SV48;
                4: mode_val = MODE_BARE_ALIAS;
                5: mode_val = 3'($urandom_range(1, 4));
                6: mode_val = 3'($urandom_range(0, 7));
                default: mode_val = MODE_SV39;
            endcase
            xlen_val = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            root_val = (ph == 0) ? 64'(ROOT_MAX) : (ph == 1) ? 64'd0 : {$urandom, $urandom};
            apb_write(REG_XLEN_IS_64, 64'(xlen_val));
            apb_write(REG_TRANSLATION_MODE, 64'(mode_val));
            apb_write(REG_ROOT_PAGE_NUMBER, root_val);
            psel    <= 1'b0;
            penable <= 1'b0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) drain_results();
                drive_item(next_walk_item(), 1'b0, no_result);
            end
        end

        // Let the last results out, then report
        drain_results();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
